// ===== rtl/core/i2c_dac_write_sequencer_top_defines.svh =====
// Assertion macros for the I2C DAC write sequencer.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef I2C_DAC_WRITE_SEQUENCER_TOP_DEFINES_SVH
`define I2C_DAC_WRITE_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define I2CDAC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define I2CDAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/i2cdac_pkg.sv =====
// Shared types, constants and the control store of the I2C DAC write sequencer.
// No dependencies; imported by i2cdac_div and i2c_dac_write_sequencer_top.
`timescale 1ns / 1ps

package i2cdac_pkg;

  localparam logic [6:0]  AddrReset = 7'd12;
  localparam logic [15:0] RefReset  = 16'd3300;
  localparam logic [6:0]  AckPolls  = 7'd6;
  localparam logic [3:0]  DivSteps  = 4'd12;
  localparam logic [11:0] CodeMax   = 12'hFFF;
  localparam logic [1:0]  LastByte  = 2'd2;
  localparam logic [2:0]  LastBit   = 3'd7;

  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_SET  = 2'd1,
    ACT_PD   = 2'd2,
    ACT_NOP  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    PD_HIZ   = 2'd0,
    PD_2K5   = 2'd1,
    PD_100K  = 2'd2,
    PD_HIZ_B = 2'd3
  } pd_mode_e;

  typedef enum logic {
    CFG_ADDR = 1'b0,
    CFG_REF  = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    PC_IDLE   = 4'd0,
    PC_START1 = 4'd1,
    PC_START2 = 4'd2,
    PC_DATA   = 4'd3,
    PC_HIGH   = 4'd4,
    PC_LOW    = 4'd5,
    PC_REL    = 4'd6,
    PC_ACKHI  = 4'd7,
    PC_POLL   = 4'd8,
    PC_STOP1  = 4'd9,
    PC_STOP2  = 4'd10,
    PC_STOP3  = 4'd11,
    PC_NSTOP1 = 4'd12,
    PC_NSTOP2 = 4'd13,
    PC_NSTOP3 = 4'd14
  } step_e;

  typedef enum logic [1:0] {
    PIN_KEEP = 2'd0,
    PIN_LOW  = 2'd1,
    PIN_HIGH = 2'd2,
    PIN_BIT  = 2'd3
  } pin_op_e;

  typedef enum logic [2:0] {
    SEQ_HOLD    = 3'd0,
    SEQ_GOTO    = 3'd1,
    SEQ_CLR_IDX = 3'd2,
    SEQ_BIT     = 3'd3,
    SEQ_ACK_ARM = 3'd4,
    SEQ_POLL    = 3'd5,
    SEQ_DONE    = 3'd6,
    SEQ_NACK    = 3'd7
  } seq_op_e;

  typedef struct packed {
    pin_op_e sda_op;
    pin_op_e scl_op;
    seq_op_e seq_op;
    step_e   next_pc;
    step_e   alt_pc;
  } ucode_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  localparam step_e NackPc = PC_NSTOP1;

  function automatic ucode_t ucode_rom(step_e pc);
    ucode_t w;
    w = '{PIN_KEEP, PIN_KEEP, SEQ_GOTO, PC_IDLE, PC_IDLE};
    unique case (pc)
      PC_IDLE:   w = '{PIN_KEEP, PIN_KEEP, SEQ_HOLD,    PC_IDLE,   PC_IDLE};
      PC_START1: w = '{PIN_LOW,  PIN_KEEP, SEQ_GOTO,    PC_START2, PC_IDLE};
      PC_START2: w = '{PIN_KEEP, PIN_LOW,  SEQ_CLR_IDX, PC_DATA,   PC_IDLE};
      PC_DATA:   w = '{PIN_BIT,  PIN_KEEP, SEQ_GOTO,    PC_HIGH,   PC_IDLE};
      PC_HIGH:   w = '{PIN_KEEP, PIN_HIGH, SEQ_GOTO,    PC_LOW,    PC_IDLE};
      PC_LOW:    w = '{PIN_KEEP, PIN_LOW,  SEQ_BIT,     PC_DATA,   PC_REL};
      PC_REL:    w = '{PIN_HIGH, PIN_KEEP, SEQ_GOTO,    PC_ACKHI,  PC_IDLE};
      PC_ACKHI:  w = '{PIN_KEEP, PIN_HIGH, SEQ_ACK_ARM, PC_POLL,   PC_IDLE};
      PC_POLL:   w = '{PIN_KEEP, PIN_KEEP, SEQ_POLL,    PC_DATA,   PC_STOP1};
      PC_STOP1:  w = '{PIN_LOW,  PIN_KEEP, SEQ_GOTO,    PC_STOP2,  PC_IDLE};
      PC_STOP2:  w = '{PIN_KEEP, PIN_HIGH, SEQ_GOTO,    PC_STOP3,  PC_IDLE};
      PC_STOP3:  w = '{PIN_HIGH, PIN_KEEP, SEQ_DONE,    PC_IDLE,   PC_IDLE};
      PC_NSTOP1: w = '{PIN_LOW,  PIN_KEEP, SEQ_GOTO,    PC_NSTOP2, PC_IDLE};
      PC_NSTOP2: w = '{PIN_KEEP, PIN_HIGH, SEQ_GOTO,    PC_NSTOP3, PC_IDLE};
      PC_NSTOP3: w = '{PIN_HIGH, PIN_KEEP, SEQ_NACK,    PC_IDLE,   PC_IDLE};
      default:   w = '{PIN_KEEP, PIN_KEEP, SEQ_GOTO,    PC_IDLE,   PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/i2cdac_div.sv =====
// Restoring divider for the DAC code: (millivolts * 4096) / reference, saturated.
// Depends on i2cdac_pkg for the step count, the saturated code and the status type.
`timescale 1ns / 1ps

module i2cdac_div import i2cdac_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] dividend_i,
  input  logic [15:0] divisor_i,
  output div_stat_t   stat_o,
  output logic [11:0] code_o
);

  logic        run_q, run_d;
  logic        sat_q, sat_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [15:0] rem_q, rem_d;
  logic [15:0] ref_q, ref_d;
  logic [11:0] quot_q, quot_d;
  logic [16:0] shifted;
  logic        ge;
  logic        last_step;

  assign shifted   = {rem_q, 1'b0};
  assign ge        = shifted >= {1'b0, ref_q};
  assign last_step = sat_q || (cnt_q == 4'd1);

  always_comb begin
    run_d  = run_q;
    sat_d  = sat_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    ref_d  = ref_q;
    quot_d = quot_q;
    if (start_i) begin
      run_d  = 1'b1;
      sat_d  = (divisor_i == 16'd0) || (dividend_i >= divisor_i);
      cnt_d  = DivSteps;
      rem_d  = dividend_i;
      ref_d  = divisor_i;
      quot_d = 12'd0;
    end else if (run_q) begin
      run_d  = !last_step;
      cnt_d  = cnt_q - 4'd1;
      rem_d  = ge ? 16'(shifted - {1'b0, ref_q}) : shifted[15:0];
      quot_d = {quot_q[10:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= 4'd0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sat_q  <= sat_d;
    rem_q  <= rem_d;
    ref_q  <= ref_d;
    quot_q <= quot_d;
  end

  assign stat_o.busy = run_q;
  assign stat_o.done = run_q && last_step;
  assign code_o      = sat_q ? CodeMax : {quot_q[10:0], ge};

endmodule

// ===== rtl/core/i2c_dac_write_sequencer_top.sv =====
// Channel    Group   Payload, lowest bit first
// request    s_axis  tuser: action; tdata: millivolts, powerdown_mode, sda_in
// result     m_axis  tdata: scl_out, sda_out, busy_res, done_res, nack_error, rejected
// config     cfg     cfg_idx_i 0 device_address, 1 reference_millivolts
//
// One request per cycle and one result per request, held in an output register.
// A set-voltage command accepted while idle holds s_axis_tready low while the
// divider produces the code, a shorter stall when the code saturates.
// Reset is asynchronous and active low; the bus lines reset released high.
// s_axis_tready also waits on m_axis_tready while a result is pending.
// Depends on i2cdac_pkg, i2cdac_div and i2c_dac_write_sequencer_top_defines.svh.
`timescale 1ns / 1ps
`include "i2c_dac_write_sequencer_top_defines.svh"

module i2c_dac_write_sequencer_top import i2cdac_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // millivolts[15:0], powerdown_mode[17:16], sda_in[18]
  input  logic [1:0]  s_axis_tuser,   // action[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // scl, sda, busy, done, nack, rejected
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  logic [6:0]  addr_q;
  logic [15:0] ref_q;
  step_e       pc_q, pc_d;
  logic [1:0]  byte_q, byte_d;
  logic [2:0]  bit_q, bit_d;
  logic [6:0]  poll_q, poll_d;
  logic [6:0]  poll_inc;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;
  logic [11:0] last_code_q, last_code_d;
  logic [15:0] frame_q, frame_d;
  logic        out_valid_q;
  logic [7:0]  out_data_q;

  logic        in_acc;
  action_e     action;
  logic [15:0] millivolts;
  pd_mode_e    pd_mode;
  logic        sda_in;
  logic        idle;
  logic        div_start;
  div_stat_t   div_stat;
  logic [11:0] div_code;
  ucode_t      uw;
  logic [7:0]  cur_byte;
  logic [1:0]  pd_bits;
  logic        done_flag, nack_flag, rej_flag;

  assign action     = action_e'(s_axis_tuser);
  assign millivolts = s_axis_tdata[15:0];
  assign pd_mode    = pd_mode_e'(s_axis_tdata[17:16]);
  assign sda_in     = s_axis_tdata[18];

  assign s_axis_tready = !div_stat.busy && (!out_valid_q || m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign idle          = (pc_q == PC_IDLE);
  assign div_start     = in_acc && (action == ACT_SET) && idle;

  i2cdac_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (millivolts),
    .divisor_i  (ref_q),
    .stat_o     (div_stat),
    .code_o     (div_code)
  );

  assign uw       = ucode_rom(pc_q);
  assign poll_inc = poll_q + 7'd1;

  always_comb begin
    unique case (byte_q)
      2'd0:    cur_byte = {addr_q, 1'b0};
      2'd1:    cur_byte = frame_q[15:8];
      default: cur_byte = frame_q[7:0];
    endcase
  end

  always_comb begin
    unique case (pd_mode)
      PD_2K5:  pd_bits = 2'b01;
      PD_100K: pd_bits = 2'b10;
      default: pd_bits = 2'b11;
    endcase
  end

  always_comb begin
    pc_d        = pc_q;
    byte_d      = byte_q;
    bit_d       = bit_q;
    poll_d      = poll_q;
    scl_d       = scl_q;
    sda_d       = sda_q;
    last_code_d = last_code_q;
    frame_d     = frame_q;
    done_flag   = 1'b0;
    nack_flag   = 1'b0;
    rej_flag    = 1'b0;

    if (div_stat.done) begin
      last_code_d = div_code;
      frame_d     = {4'd0, div_code};
    end

    if (in_acc) begin
      unique case (action)
        ACT_SET, ACT_PD: begin
          if (!idle) begin
            rej_flag = 1'b1;
          end else begin
            byte_d = 2'd0;
            bit_d  = 3'd0;
            poll_d = 7'd0;
            pc_d   = PC_START1;
            if (action == ACT_PD) begin
              frame_d = {2'b00, pd_bits, last_code_q};
            end
          end
        end
        ACT_TICK: begin
          unique case (uw.sda_op)
            PIN_LOW:  sda_d = 1'b0;
            PIN_HIGH: sda_d = 1'b1;
            PIN_BIT:  sda_d = cur_byte[3'(~bit_q)];
            default:  sda_d = sda_q;
          endcase
          unique case (uw.scl_op)
            PIN_LOW:  scl_d = 1'b0;
            PIN_HIGH: scl_d = 1'b1;
            default:  scl_d = scl_q;
          endcase
          unique case (uw.seq_op)
            SEQ_HOLD: pc_d = pc_q;
            SEQ_GOTO: pc_d = uw.next_pc;
            SEQ_CLR_IDX: begin
              byte_d = 2'd0;
              bit_d  = 3'd0;
              pc_d   = uw.next_pc;
            end
            SEQ_BIT: begin
              if (bit_q >= LastBit) begin
                pc_d = uw.alt_pc;
              end else begin
                bit_d = bit_q + 3'd1;
                pc_d  = uw.next_pc;
              end
            end
            SEQ_ACK_ARM: begin
              poll_d = 7'd0;
              pc_d   = uw.next_pc;
            end
            SEQ_POLL: begin
              if (!sda_in) begin
                scl_d = 1'b0;
                if (byte_q >= LastByte) begin
                  pc_d = uw.alt_pc;
                end else begin
                  byte_d = byte_q + 2'd1;
                  bit_d  = 3'd0;
                  pc_d   = uw.next_pc;
                end
              end else begin
                poll_d = poll_inc;
                if (poll_inc >= AckPolls) begin
                  scl_d = 1'b0;
                  pc_d  = NackPc;
                end
              end
            end
            SEQ_DONE: begin
              done_flag = 1'b1;
              pc_d      = uw.next_pc;
            end
            SEQ_NACK: begin
              nack_flag = 1'b1;
              pc_d      = uw.next_pc;
            end
            default: pc_d = PC_IDLE;
          endcase
        end
        default: pc_d = pc_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q      <= AddrReset;
      ref_q       <= RefReset;
      pc_q        <= PC_IDLE;
      byte_q      <= 2'd0;
      bit_q       <= 3'd0;
      poll_q      <= 7'd0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      last_code_q <= 12'd0;
      frame_q     <= 16'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          CFG_ADDR: addr_q <= cfg_wdata_i[6:0];
          CFG_REF:  ref_q  <= cfg_wdata_i;
          default:  ref_q  <= ref_q;
        endcase
      end
      pc_q        <= pc_d;
      byte_q      <= byte_d;
      bit_q       <= bit_d;
      poll_q      <= poll_d;
      scl_q       <= scl_d;
      sda_q       <= sda_d;
      last_code_q <= last_code_d;
      frame_q     <= frame_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_data_q <= {2'b00, rej_flag, nack_flag, done_flag, (pc_d != PC_IDLE), sda_d, scl_d};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `I2CDAC_ASSERT_IMPL(a_div_stalls_input, div_stat.busy, !s_axis_tready, "request taken while divider runs")
  `I2CDAC_ASSERT_IMPL(a_div_done_in_frame, div_stat.done, pc_q != PC_IDLE, "code finished outside a frame")
  `I2CDAC_ASSERT_NEXT(a_set_starts_div, div_start, div_stat.busy && (pc_q == PC_START1), "set command did not start divider")
  `I2CDAC_ASSERT_IMPL(a_flags_exclusive, in_acc, !(done_flag && nack_flag) && !(rej_flag && idle), "conflicting result flags")

endmodule
